>>> src/lfps_pkg.sv
// lfps_pkg: shared types and constants for likelihood-field particle scoring.
// No dependencies; imported by every module of the block.
package lfps_pkg;

	localparam int GRID_MAX_WIDTH_DEF  = 512;
	localparam int GRID_MAX_HEIGHT_DEF = 512;

	localparam int TDATA_IN_W  = 136;
	localparam int TUSER_IN_W  = 3;
	localparam int TDATA_OUT_W = 72;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	localparam int WEIGHT_W = 26;
	localparam int TOTAL_W  = 42;
	localparam int WORLD_W  = 36;

	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_POSE = 2'd1,
		KIND_BEAM = 2'd2
	} kind_t;

	localparam logic [1:0] CLASS_OCCUPIED = 2'd1;
	localparam logic [1:0] CLASS_UNKNOWN  = 2'd2;

	localparam logic [2:0] REG_HIT_GAIN    = 3'd0;
	localparam logic [2:0] REG_RAND_TERM   = 3'd1;
	localparam logic [2:0] REG_OUTSIDE     = 3'd2;
	localparam logic [2:0] REG_ORIGIN_X    = 3'd3;
	localparam logic [2:0] REG_ORIGIN_Y    = 3'd4;
	localparam logic [2:0] REG_CELLS_PER_M = 3'd5;
	localparam logic [2:0] REG_GRID_WIDTH  = 3'd6;
	localparam logic [2:0] REG_GRID_HEIGHT = 3'd7;

	localparam logic [16:0] ONE_Q16     = 17'd65536;
	localparam logic [9:0]  PENALTY_Q16 = 10'd655;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROT,
		ST_SUM,
		ST_CELL,
		ST_ADDR,
		ST_RD,
		ST_MIX,
		ST_SQR,
		ST_CUBE,
		ST_ACC,
		ST_FIN,
		ST_PCLS
	} state_t;

	typedef struct packed {
		logic accept;
		logic acc;
		logic fin;
		logic pose_cls;
	} cmd_t;

	typedef struct packed {
		logic  in_valid;
		kind_t in_kind;
		logic  is_pose;
		logic  last;
		logic  out_busy;
	} status_t;

endpackage

>>> src/lfps_datapath.sv
// lfps_datapath: config registers, pose/accumulator state, map store and the
// staged beam arithmetic. Depends on lfps_pkg; driven by lfps_ctrl commands.
module lfps_datapath import lfps_pkg::*; #(
	parameter int GRID_MAX_WIDTH  = GRID_MAX_WIDTH_DEF,
	parameter int GRID_MAX_HEIGHT = GRID_MAX_HEIGHT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic [TDATA_IN_W-1:0]  s_tdata,
	input  logic [TUSER_IN_W-1:0]  s_tuser,
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  cmd_t                   cmd,
	output status_t                status
);

	localparam int XW    = $clog2(GRID_MAX_WIDTH);
	localparam int YW    = $clog2(GRID_MAX_HEIGHT);
	localparam int DEPTH = GRID_MAX_WIDTH * GRID_MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	// config
	logic [15:0]        hit_gain_q, rand_term_q, outside_q;
	logic signed [31:0] origin_x_q, origin_y_q;
	logic [31:0]        cpm_q;
	logic [9:0]         grid_w_q, grid_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_gain_q <= 16'd62259;
			rand_term_q <= 16'd164;
			outside_q <= '0;
			origin_x_q <= '0;
			origin_y_q <= '0;
			cpm_q <= 32'd1310720;
			grid_w_q <= 10'd512;
			grid_h_q <= 10'd512;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HIT_GAIN:    hit_gain_q <= cfg_wdata[15:0];
				REG_RAND_TERM:   rand_term_q <= cfg_wdata[15:0];
				REG_OUTSIDE:     outside_q <= cfg_wdata[15:0];
				REG_ORIGIN_X:    origin_x_q <= $signed(cfg_wdata);
				REG_ORIGIN_Y:    origin_y_q <= $signed(cfg_wdata);
				REG_CELLS_PER_M: cpm_q <= cfg_wdata;
				REG_GRID_WIDTH:  grid_w_q <= cfg_wdata[9:0];
				REG_GRID_HEIGHT: grid_h_q <= cfg_wdata[9:0];
			endcase
		end
	end

	// input fields
	logic [17:0]        in_cell_index;
	logic [15:0]        in_lik;
	logic [1:0]         in_class;
	logic signed [31:0] in_px, in_py;
	logic signed [15:0] in_cos, in_sin;
	kind_t              in_kind;

	assign in_cell_index = s_tdata[17:0];
	assign in_lik        = s_tdata[33:18];
	assign in_class      = s_tdata[35:34];
	assign in_px         = $signed(s_tdata[67:36]);
	assign in_py         = $signed(s_tdata[99:68]);
	assign in_cos        = $signed(s_tdata[115:100]);
	assign in_sin        = $signed(s_tdata[131:116]);
	assign in_kind       = kind_t'(s_tuser[1:0]);

	// map store
	logic [17:0]   mem [DEPTH];
	logic          store_wr;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [17:0]   rd_q;

	assign store_wr = cmd.accept && (in_kind == KIND_LOAD) &&
		(32'(in_cell_index) < 32'(DEPTH));
	assign wr_addr = AW'(32'(in_cell_index));

	always_ff @(posedge clk) begin
		if (store_wr)
			mem[wr_addr] <= {in_class, in_lik};
		rd_q <= mem[rd_addr];
	end

	// item and pose state
	kind_t              it_kind_q;
	logic               it_last_q;
	logic signed [31:0] it_px_q, it_py_q;
	logic signed [31:0] pose_x_q, pose_y_q;
	logic signed [15:0] pose_cos_q, pose_sin_q;
	logic [1:0]         pose_class_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                m_tvalid_q;
	logic [WEIGHT_W-1:0] out_pw_q;
	logic [TOTAL_W-1:0]  out_tot_q;

	// stage arithmetic
	logic signed [47:0] prod_a_q, prod_b_q, prod_c_q, prod_d_q;
	logic signed [48:0] diff_x, diff_y;
	logic signed [WORLD_W-1:0] wx, wy, wx_q, wy_q;
	logic signed [36:0] dx, dy;
	logic signed [53:0] mhx_q, mlx_q, mhy_q, mly_q;
	logic signed [54:0] sx, sy, cxs, cys;
	logic [13:0]        gw, gh;
	logic               in_x, in_y, inside_q;
	logic [XW-1:0]      cx_q;
	logic [YW-1:0]      cy_q;
	logic [15:0]        p;
	logic [31:0]        hp_q;
	logic [16:0]        ws, w, w_q;
	logic [33:0]        ww_q;
	logic [50:0]        www_q;
	logic [18:0]        cube;
	logic [26:0]        wsum;
	logic [42:0]        tsum;
	logic [35:0]        pen;
	logic [WEIGHT_W-1:0] pw;

	assign diff_x = (49'(prod_a_q) - 49'(prod_b_q)) >>> 14;
	assign diff_y = (49'(prod_c_q) + 49'(prod_d_q)) >>> 14;
	assign wx = (it_kind_q == KIND_POSE) ? WORLD_W'(it_px_q) :
		WORLD_W'(pose_x_q) + WORLD_W'(diff_x);
	assign wy = (it_kind_q == KIND_POSE) ? WORLD_W'(it_py_q) :
		WORLD_W'(pose_y_q) + WORLD_W'(diff_y);

	assign dx = 37'(wx_q) - 37'(origin_x_q);
	assign dy = 37'(wy_q) - 37'(origin_y_q);

	assign sx  = 55'(mhx_q) + 55'(mlx_q >>> 16);
	assign sy  = 55'(mhy_q) + 55'(mly_q >>> 16);
	assign cxs = sx >>> 16;
	assign cys = sy >>> 16;
	assign gw  = (14'(grid_w_q) > 14'(GRID_MAX_WIDTH)) ? 14'(GRID_MAX_WIDTH) : 14'(grid_w_q);
	assign gh  = (14'(grid_h_q) > 14'(GRID_MAX_HEIGHT)) ? 14'(GRID_MAX_HEIGHT) : 14'(grid_h_q);
	assign in_x = !cxs[54] && (cxs < $signed(55'(gw)));
	assign in_y = !cys[54] && (cys < $signed(55'(gh)));

	assign rd_addr = AW'(32'(cy_q) * 32'(GRID_MAX_WIDTH) + 32'(cx_q));

	assign p    = inside_q ? rd_q[15:0] : outside_q;
	assign ws   = 17'(hp_q[31:16]) + 17'(rand_term_q);
	assign w    = (ws > ONE_Q16) ? ONE_Q16 : ws;
	assign cube = www_q[50:32];
	assign wsum = 27'(weight_q) + 27'(cube);
	assign tsum = 43'(total_q) + 43'(weight_q);
	assign pen  = 36'(weight_q) * 36'(PENALTY_Q16);

	always_comb begin
		priority if (pose_class_q == CLASS_UNKNOWN)
			pw = '0;
		else if (pose_class_q == CLASS_OCCUPIED)
			pw = WEIGHT_W'(pen[35:16]);
		else
			pw = weight_q;
	end

	always_ff @(posedge clk) begin
		prod_a_q <= 48'(pose_cos_q) * 48'(it_px_q);
		prod_b_q <= 48'(pose_sin_q) * 48'(it_py_q);
		prod_c_q <= 48'(pose_sin_q) * 48'(it_px_q);
		prod_d_q <= 48'(pose_cos_q) * 48'(it_py_q);
		wx_q <= wx;
		wy_q <= wy;
		mhx_q <= 54'(dx) * 54'($signed({1'b0, cpm_q[31:16]}));
		mlx_q <= 54'(dx) * 54'($signed({1'b0, cpm_q[15:0]}));
		mhy_q <= 54'(dy) * 54'($signed({1'b0, cpm_q[31:16]}));
		mly_q <= 54'(dy) * 54'($signed({1'b0, cpm_q[15:0]}));
		cx_q <= cxs[XW-1:0];
		cy_q <= cys[YW-1:0];
		inside_q <= in_x && in_y;
		hp_q <= 32'(hit_gain_q) * 32'(p);
		w_q <= w;
		ww_q <= 34'(w) * 34'(w);
		www_q <= 51'(ww_q) * 51'(w_q);
		if (cmd.accept) begin
			it_kind_q <= in_kind;
			it_last_q <= s_tlast;
			it_px_q <= in_px;
			it_py_q <= in_py;
		end
		if (cmd.fin) begin
			out_pw_q <= pw;
			out_tot_q <= tsum[42] ? {TOTAL_W{1'b1}} : tsum[TOTAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q <= '0;
			pose_y_q <= '0;
			pose_cos_q <= 16'sd16384;
			pose_sin_q <= '0;
			pose_class_q <= CLASS_UNKNOWN;
			weight_q <= '0;
			total_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.accept && in_kind == KIND_POSE) begin
				pose_x_q <= in_px;
				pose_y_q <= in_py;
				pose_cos_q <= in_cos;
				pose_sin_q <= in_sin;
				weight_q <= '0;
				if (s_tuser[2])
					total_q <= '0;
			end
			if (cmd.pose_cls)
				pose_class_q <= inside_q ? rd_q[17:16] : CLASS_UNKNOWN;
			if (cmd.acc)
				weight_q <= wsum[26] ? {WEIGHT_W{1'b1}} : wsum[WEIGHT_W-1:0];
			if (cmd.fin) begin
				total_q <= tsum[42] ? {TOTAL_W{1'b1}} : tsum[TOTAL_W-1:0];
				weight_q <= '0;
				m_tvalid_q <= 1'b1;
			end else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, out_tot_q, out_pw_q};

	assign status.in_valid = s_tvalid;
	assign status.in_kind  = in_kind;
	assign status.is_pose  = (it_kind_q == KIND_POSE);
	assign status.last     = it_last_q;
	assign status.out_busy = m_tvalid_q && !m_tready;

endmodule

>>> src/lfps_ctrl.sv
// lfps_ctrl: sequencer that steps one item through the datapath stages.
// Depends on lfps_pkg; drives lfps_datapath through cmd_t.
module lfps_ctrl import lfps_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output logic    s_tready,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (status.in_valid &&
					(status.in_kind == KIND_POSE || status.in_kind == KIND_BEAM))
					state_d = ST_ROT;
			end
			ST_ROT:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_CELL;
			ST_CELL: state_d = ST_ADDR;
			ST_ADDR: state_d = ST_RD;
			ST_RD:   state_d = status.is_pose ? ST_PCLS : ST_MIX;
			ST_MIX:  state_d = ST_SQR;
			ST_SQR:  state_d = ST_CUBE;
			ST_CUBE: state_d = ST_ACC;
			ST_ACC:  state_d = status.last ? ST_FIN : ST_IDLE;
			ST_FIN: begin
				if (!status.out_busy)
					state_d = ST_IDLE;
			end
			ST_PCLS: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		cmd = '0;
		cmd.accept = (state_q == ST_IDLE) && status.in_valid;
		cmd.acc = (state_q == ST_ACC);
		cmd.fin = (state_q == ST_FIN) && !status.out_busy;
		cmd.pose_cls = (state_q == ST_PCLS);
	end

endmodule

>>> src/likelihood_field_particle_scoring_top.sv
// Top level of likelihood-field particle scoring: stream ports, config port.
// Depends on lfps_pkg, lfps_ctrl and lfps_datapath.
//
// Load items write one map cell. The sequencer steps pose and beam items through
// rotation, cell conversion and the registered map read; beams then go through
// the cube multiplies, and the last beam of a particle adds a finish step. A
// pending result does not block input; only a second result waits until the
// first is taken. The map store is not cleared: read only cells that were
// loaded.
module likelihood_field_particle_scoring_top import lfps_pkg::*; #(
	parameter int GRID_MAX_WIDTH  = GRID_MAX_WIDTH_DEF,
	parameter int GRID_MAX_HEIGHT = GRID_MAX_HEIGHT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// cell_index, cell_likelihood, cell_class, pos_x, pos_y, cos_heading, sin_heading
	input  logic [TDATA_IN_W-1:0]  s_tdata,
	// kind, first_particle
	input  logic [TUSER_IN_W-1:0]  s_tuser,
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// particle_weight, running_total
	output logic [TDATA_OUT_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cmd_t    cmd;
	status_t status;

	lfps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	lfps_datapath #(
		.GRID_MAX_WIDTH  (GRID_MAX_WIDTH),
		.GRID_MAX_HEIGHT (GRID_MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

>>> src/lfps_checker.sv
// lfps_checker: port-level assertions for the scoring block, bound to the top.
// Depends on lfps_pkg and likelihood_field_particle_scoring_top.
module lfps_checker import lfps_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [TUSER_IN_W-1:0]  s_tuser,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [TDATA_OUT_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result transaction dropped or changed while stalled");

	a_beam_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[1:0] == KIND_BEAM |=> !s_tready)
		else $error("beam transaction did not occupy the block");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a beam in flight");

	a_weight_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[25:0] <= m_tdata[67:26])
		else $error("particle weight exceeds running total");

endmodule

bind likelihood_field_particle_scoring_top lfps_checker u_lfps_checker (.*);

>>> bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for likelihood_field_particle_scoring_top.
// Drives load/pose/beam transactions, predicts each particle result and checks the output stream.
// Depends on lfps_pkg and the top-level RTL only.
module tb;
	import lfps_pkg::*;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int MAP_DEPTH = 262144;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic [1:0]         kind;
		logic [17:0]        idx;
		logic [15:0]        lik;
		logic [1:0]         cls;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] c;
		logic signed [15:0] s;
		bit                 first;
		bit                 last;
	} item_t;

	typedef struct {
		logic [WEIGHT_W-1:0] weight;
		logic [TOTAL_W-1:0]  total;
	} score_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [TDATA_IN_W-1:0] s_tdata = '0;
	logic [TUSER_IN_W-1:0] s_tuser = '0;
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	likelihood_field_particle_scoring_top dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// model state
	bit [15:0] lik_map [MAP_DEPTH];
	bit [1:0]  cls_map [MAP_DEPTH];
	bit        loaded [MAP_DEPTH];
	longint hit_gain = 62259, rand_term = 164, outside_lik = 0;
	longint org_x = 0, org_y = 0, cpm = 1310720, grid_w = 512, grid_h = 512;
	longint pose_x = 0, pose_y = 0, pose_c = 16384, pose_s = 0;
	logic [1:0] pose_cls = CLASS_UNKNOWN;
	longint weight_acc = 0, total_acc = 0;

	item_t  pending_items [$];
	score_t expected_scores [$];
	bit     failed = 0;
	bit     no_idle = 0;
	int     hold_req = 0, hold_ack = 0;
	int     cycles = 0;

	function automatic longint to_cell(longint w, longint org);
		logic signed [127:0] d, p;
		d = w - org;
		p = d * $signed({96'd0, cpm[31:0]});
		return longint'(p >>> 32);
	endfunction

	function automatic bit map_cell(longint wx, longint wy, output int addr);
		longint gw, gh, cx, cy;
		gw = grid_w < 512 ? grid_w : 512;
		gh = grid_h < 512 ? grid_h : 512;
		cx = to_cell(wx, org_x);
		cy = to_cell(wy, org_y);
		addr = 0;
		if (cx < 0 || cy < 0 || cx >= gw || cy >= gh)
			return 0;
		addr = int'(cy * 512 + cx);
		return 1;
	endfunction

	function automatic item_t load_item(int addr, logic [15:0] lik, logic [1:0] cls);
		item_t it;
		it = '{kind: KIND_LOAD, idx: addr[17:0], lik: lik, cls: cls,
			x: $urandom, y: $urandom, c: $urandom, s: $urandom,
			first: $urandom_range(0, 1), last: $urandom_range(0, 1)};
		return it;
	endfunction

	function automatic void enqueue(item_t it);
		pending_items.insert(pending_items.size(), it);
		if (it.kind == KIND_LOAD) begin
			lik_map[it.idx] = it.lik;
			cls_map[it.idx] = it.cls;
			loaded[it.idx] = 1;
		end
	endfunction

	// pushes the item, first loading any cell it would read that was never written
	function automatic void push_item(item_t it);
		int addr;
		longint wx, wy, p, w, cube, pw;
		score_t sc;
		if (it.kind == KIND_POSE) begin
			if (map_cell(it.x, it.y, addr)) begin
				if (!loaded[addr])
					enqueue(load_item(addr, $urandom, $urandom_range(0, 3)));
				pose_cls = cls_map[addr];
			end else
				pose_cls = CLASS_UNKNOWN;
			pose_x = it.x;
			pose_y = it.y;
			pose_c = it.c;
			pose_s = it.s;
			weight_acc = 0;
			if (it.first)
				total_acc = 0;
		end else if (it.kind == KIND_BEAM) begin
			wx = pose_x + ((pose_c * longint'(it.x) - pose_s * longint'(it.y)) >>> 14);
			wy = pose_y + ((pose_s * longint'(it.x) + pose_c * longint'(it.y)) >>> 14);
			if (map_cell(wx, wy, addr)) begin
				if (!loaded[addr])
					enqueue(load_item(addr, $urandom, $urandom_range(0, 3)));
				p = lik_map[addr];
			end else
				p = outside_lik;
			w = ((hit_gain * p) >> 16) + rand_term;
			if (w > 65536)
				w = 65536;
			cube = (w * w * w) >> 32;
			weight_acc += cube;
			if (weight_acc > 64'h3FFFFFF)
				weight_acc = 64'h3FFFFFF;
			if (it.last) begin
				total_acc += weight_acc;
				if (total_acc > 64'h3FFFFFFFFFF)
					total_acc = 64'h3FFFFFFFFFF;
				pw = weight_acc;
				if (pose_cls == CLASS_UNKNOWN)
					pw = 0;
				else if (pose_cls == CLASS_OCCUPIED)
					pw = (pw * PENALTY_Q16) >> 16;
				sc.weight = pw[WEIGHT_W-1:0];
				sc.total = total_acc[TOTAL_W-1:0];
				expected_scores.insert(expected_scores.size(), sc);
				weight_acc = 0;
			end
		end
		enqueue(it);
	endfunction

	function automatic item_t pose_item(longint x, longint y, longint c, longint s, bit first);
		item_t it;
		it = load_item($urandom, $urandom, $urandom);
		it.kind = KIND_POSE;
		it.x = x;
		it.y = y;
		it.c = c;
		it.s = s;
		it.first = first;
		return it;
	endfunction

	function automatic item_t beam_item(longint x, longint y, bit last);
		item_t it;
		it = load_item($urandom, $urandom, $urandom);
		it.kind = KIND_BEAM;
		it.x = x;
		it.y = y;
		it.last = last;
		return it;
	endfunction

	function automatic longint rand_trig();
		return longint'($urandom_range(0, 32768)) - 16384;
	endfunction

	// mostly well-formed particles inside the map, plus noise of every kind
	function automatic void random_particles(int n, longint span);
		int cnt, nb;
		item_t it;
		cnt = 0;
		while (cnt < n) begin
			if ($urandom_range(0, 9) == 0) begin
				it = load_item($urandom, $urandom, $urandom_range(0, 3));
				it.kind = $urandom_range(0, 3);
				push_item(it);
				cnt++;
			end else begin
				push_item(pose_item($urandom_range(0, span), $urandom_range(0, span),
					rand_trig(), rand_trig(), $urandom_range(0, 7) == 0));
				nb = $urandom_range(1, 8);
				for (int b = 0; b < nb; b++)
					push_item(beam_item(longint'($urandom_range(0, span)) - span / 2,
						longint'($urandom_range(0, span)) - span / 2, b == nb - 1));
				cnt += nb + 1;
			end
		end
	endfunction

	task automatic wait_idle();
		wait (pending_items.size() == 0 && !s_tvalid && expected_scores.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_HIT_GAIN:    hit_gain = val[15:0];
			REG_RAND_TERM:   rand_term = val[15:0];
			REG_OUTSIDE:     outside_lik = val[15:0];
			REG_ORIGIN_X:    org_x = longint'($signed(val));
			REG_ORIGIN_Y:    org_y = longint'($signed(val));
			REG_CELLS_PER_M: cpm = val;
			REG_GRID_WIDTH:  grid_w = val[9:0];
			REG_GRID_HEIGHT: grid_h = val[9:0];
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// sender
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		item_t it;
		if (!arst_n) begin
			s_tvalid <= 0;
			gap <= 0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (gap > 0) begin
				s_tvalid <= 0;
				gap <= gap - 1;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				s_tdata <= {4'd0, it.s, it.c, it.y, it.x, it.cls, it.lik, it.idx};
				s_tuser <= {it.first, it.kind};
				s_tlast <= it.last;
				s_tvalid <= 1;
				gap <= no_idle ? 0 : $urandom_range(0, 3);
			end else
				s_tvalid <= 0;
		end
	end

	// receiver
	int stall = 0, hold = 0;
	always @(posedge clk or negedge arst_n) begin
		score_t sc;
		logic [WEIGHT_W-1:0] got_w;
		logic [TOTAL_W-1:0] got_t;
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			got_w = m_tdata[WEIGHT_W-1:0];
			got_t = m_tdata[WEIGHT_W+TOTAL_W-1:WEIGHT_W];
			if (m_tvalid && m_tready) begin
				if (expected_scores.size() == 0) begin
					$display("%0t: unexpected result weight %0d total %0d", $time, got_w, got_t);
					failed = 1;
				end else begin
					sc = expected_scores.pop_front();
					if (got_w !== sc.weight) begin
						$display("%0t: particle_weight expected %0d actual %0d",
							$time, sc.weight, got_w);
						failed = 1;
					end
					if (got_t !== sc.total) begin
						$display("%0t: running_total expected %0d actual %0d",
							$time, sc.total, got_t);
						failed = 1;
					end
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				hold <= 400;
				m_tready <= 0;
			end else if (hold > 0) begin
				hold <= hold - 1;
				m_tready <= 0;
			end else if (m_tvalid && m_tready) begin
				stall <= no_idle ? 0 : $urandom_range(0, 3);
				m_tready <= no_idle;
			end else if (stall > 0) begin
				stall <= stall - 1;
				m_tready <= 0;
			end else
				m_tready <= 1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("likelihood_field_particle_scoring_top: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// directed: beams on the reset pose, store extremes, heading extremes, spare kind
		push_item(beam_item(65536, 65536, 0));
		push_item(beam_item(32'sh7FFFFFFF, 32'sh80000000, 1));
		push_item(load_item(0, 16'hFFFF, 2'd0));
		push_item(load_item(262143, 16'h0000, 2'd3));
		push_item(load_item(21, 16'h8000, CLASS_OCCUPIED));
		push_item(pose_item(65536, 0, -16384, 16384, 1));
		push_item(beam_item(0, 0, 0));
		push_item(beam_item(-65536, 0, 1));
		push_item(load_item(42, 16'h1234, 2'd3));
		push_item(pose_item(131072 + 1024, 32768, 16384, -16384, 0));
		push_item(beam_item(0, 0, 1));
		push_item(pose_item(-65536, 0, 0, 0, 0));
		push_item(beam_item(32'sh80000000, 32'sh7FFFFFFF, 1));
		push_item(pose_item(32'sh7FFFFFFF, 32'sh80000000, 16384, 0, 1));
		push_item(beam_item(0, 0, 1));
		begin
			item_t sp;
			sp = beam_item(0, 0, 1);
			sp.kind = KIND_SPARE;
			push_item(sp);
		end
		push_item(pose_item(65536 * 3, 65536 * 3, 11585, 11585, 0));
		push_item(beam_item(65536, 65536, 1));
		random_particles(100, 25 * 65536);
		wait_idle();

		// every register written, map widths beyond the max and zero height
		write_reg(REG_HIT_GAIN, 65535);
		write_reg(REG_RAND_TERM, 0);
		write_reg(REG_OUTSIDE, 40000);
		write_reg(REG_ORIGIN_X, -5 * 65536);
		write_reg(REG_ORIGIN_Y, 32'h80000000);
		write_reg(REG_CELLS_PER_M, 32'hFFFFFFFF);
		write_reg(REG_GRID_WIDTH, 1023);
		write_reg(REG_GRID_HEIGHT, 0);
		no_idle = 1;
		random_particles(60, 25 * 65536);
		wait_idle();
		no_idle = 0;

		// point weight from the random term alone on every beam of one long particle
		write_reg(REG_HIT_GAIN, 0);
		write_reg(REG_RAND_TERM, 65535);
		write_reg(REG_ORIGIN_X, 0);
		write_reg(REG_ORIGIN_Y, 0);
		write_reg(REG_CELLS_PER_M, 0);
		write_reg(REG_GRID_WIDTH, 1);
		write_reg(REG_GRID_HEIGHT, 1);
		push_item(pose_item(0, 0, 16384, 0, 1));
		for (int b = 0; b < 40; b++)
			push_item(beam_item($urandom, $urandom, b == 39));
		random_particles(30, 4 * 65536);
		wait_idle();

		// small grid with offset origin; receiver holds off while short particles pile up
		write_reg(REG_HIT_GAIN, 32768);
		write_reg(REG_RAND_TERM, 1000);
		write_reg(REG_OUTSIDE, 0);
		write_reg(REG_ORIGIN_X, 65536);
		write_reg(REG_ORIGIN_Y, 32'h7FFFFFFF);
		write_reg(REG_CELLS_PER_M, 655360);
		write_reg(REG_GRID_WIDTH, 64);
		write_reg(REG_GRID_HEIGHT, 48);
		random_particles(50, 8 * 65536);
		wait_idle();
		write_reg(REG_ORIGIN_Y, -65536);
		hold_req = 1;
		for (int k = 0; k < 12; k++) begin
			push_item(pose_item($urandom_range(0, 7 * 65536), $urandom_range(0, 5 * 65536),
				rand_trig(), rand_trig(), 0));
			push_item(beam_item($urandom_range(0, 65536), $urandom_range(0, 65536), 1));
		end
		random_particles(50, 7 * 65536);
		wait_idle();

		// back to the reset values
		write_reg(REG_HIT_GAIN, 62259);
		write_reg(REG_RAND_TERM, 164);
		write_reg(REG_ORIGIN_X, 0);
		write_reg(REG_ORIGIN_Y, 0);
		write_reg(REG_CELLS_PER_M, 1310720);
		write_reg(REG_GRID_WIDTH, 512);
		write_reg(REG_GRID_HEIGHT, 512);
		random_particles(50, 25 * 65536);
		wait_idle();

		if (!failed)
			$display("likelihood_field_particle_scoring_top: match");
		else
			$display("likelihood_field_particle_scoring_top: mismatch");
		$finish;
	end
endmodule

>>> likelihood_field_particle_scoring_top.f
src/lfps_pkg.sv
src/lfps_datapath.sv
src/lfps_ctrl.sv
src/likelihood_field_particle_scoring_top.sv
src/lfps_checker.sv
bench/tb.sv
